[hw/rtl/jsu_pkg.sv]
// Package for the JSON string unescaper: mode codes, result kinds, error codes
// and the job record that passes from the front end to the back end.
// No dependencies.
`timescale 1ns / 1ps

package jsu_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   typedef enum logic [2:0] {
      MODE_WAIT    = 3'd0,
      MODE_BODY    = 3'd1,
      MODE_ESC     = 3'd2,
      MODE_HEX1    = 3'd3,
      MODE_NEED_BS = 3'd4,
      MODE_NEED_U  = 3'd5,
      MODE_HEX2    = 3'd6
   } mode_type;

   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_DONE  = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam logic [3:0] ERR_NONE         = 4'd0;
   localparam logic [3:0] ERR_NO_QUOTE     = 4'd1;
   localparam logic [3:0] ERR_CUT_ESCAPE   = 4'd2;
   localparam logic [3:0] ERR_CUT_HEX      = 4'd3;
   localparam logic [3:0] ERR_BAD_HEX      = 4'd4;
   localparam logic [3:0] ERR_LONE_HIGH    = 4'd5;
   localparam logic [3:0] ERR_BAD_LOW      = 4'd6;
   localparam logic [3:0] ERR_LONE_LOW     = 4'd7;
   localparam logic [3:0] ERR_BAD_ESCAPE   = 4'd8;
   localparam logic [3:0] ERR_UNTERMINATED = 4'd9;

   // One job holds every result of one input byte.
   typedef struct packed {
      logic        is_cp;
      logic [1:0]  kind;
      logic [20:0] value;
      logic [3:0]  error_code;
   } job_type;

endpackage

[hw/rtl/jsu_front.sv]
// Front end: accepts text bytes, runs the string state machine and emits one
// job per byte that produces results. Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic [7:0]      text_byte,
   input  logic            end_of_text,
   output logic            job_valid,
   output jsu_pkg::job_type job
);

   jsu_pkg::mode_type mode_ff, mode_in;
   logic [15:0] hex_accum_ff, hex_accum_in;
   logic [1:0]  hex_count_ff, hex_count_in;
   logic [9:0]  high_half_ff, high_half_in;

   logic        hex_ok;
   logic [3:0]  hex_digit;
   logic [15:0] unit;
   logic        unit_high;
   logic        unit_low;
   logic        has_result;

   always_comb begin
      hex_ok    = 1'b1;
      hex_digit = 4'd0;
      if (text_byte inside {[8'h30:8'h39]}) begin
         hex_digit = text_byte[3:0];
      end else if (text_byte inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
         hex_digit = text_byte[3:0] + 4'd9;
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign unit      = {hex_accum_ff[11:0], hex_digit};
   assign unit_high = (unit[15:10] == 6'b110110);
   assign unit_low  = (unit[15:10] == 6'b110111);

   always_comb begin
      mode_in         = mode_ff;
      hex_accum_in    = hex_accum_ff;
      hex_count_in    = hex_count_ff;
      high_half_in    = high_half_ff;
      has_result      = 1'b0;
      job.is_cp       = 1'b0;
      job.kind        = jsu_pkg::KIND_BYTE;
      job.value       = {13'd0, text_byte};
      job.error_code  = jsu_pkg::ERR_NONE;

      case (mode_ff)
         jsu_pkg::MODE_BODY: begin
            if (end_of_text) begin
               has_result     = 1'b1;
               job.kind       = jsu_pkg::KIND_ERROR;
               job.error_code = jsu_pkg::ERR_UNTERMINATED;
               mode_in        = jsu_pkg::MODE_WAIT;
            end else if (text_byte == 8'h22) begin
               has_result = 1'b1;
               job.kind   = jsu_pkg::KIND_DONE;
               mode_in    = jsu_pkg::MODE_WAIT;
            end else if (text_byte == 8'h5C) begin
               mode_in = jsu_pkg::MODE_ESC;
            end else begin
               has_result = 1'b1;
            end
         end
         jsu_pkg::MODE_ESC: begin
            has_result = 1'b1;
            mode_in    = jsu_pkg::MODE_BODY;
            if (end_of_text) begin
               job.kind       = jsu_pkg::KIND_ERROR;
               job.error_code = jsu_pkg::ERR_CUT_ESCAPE;
               mode_in        = jsu_pkg::MODE_WAIT;
            end else begin
               case (text_byte)
                  8'h22, 8'h5C, 8'h2F: job.value = {13'd0, text_byte};
                  8'h62: job.value = 21'h08;
                  8'h66: job.value = 21'h0C;
                  8'h6E: job.value = 21'h0A;
                  8'h72: job.value = 21'h0D;
                  8'h74: job.value = 21'h09;
                  8'h75: begin
                     has_result   = 1'b0;
                     mode_in      = jsu_pkg::MODE_HEX1;
                     hex_accum_in = 16'd0;
                     hex_count_in = 2'd0;
                  end
                  default: begin
                     job.kind       = jsu_pkg::KIND_ERROR;
                     job.error_code = jsu_pkg::ERR_BAD_ESCAPE;
                     mode_in        = jsu_pkg::MODE_WAIT;
                  end
               endcase
            end
         end
         jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
            if (end_of_text || !hex_ok) begin
               has_result     = 1'b1;
               job.kind       = jsu_pkg::KIND_ERROR;
               job.error_code = end_of_text ? jsu_pkg::ERR_CUT_HEX : jsu_pkg::ERR_BAD_HEX;
               mode_in        = jsu_pkg::MODE_WAIT;
            end else if (hex_count_ff != 2'd3) begin
               hex_accum_in = unit;
               hex_count_in = hex_count_ff + 2'd1;
            end else begin
               hex_accum_in = 16'd0;
               hex_count_in = 2'd0;
               if (mode_ff == jsu_pkg::MODE_HEX1) begin
                  if (unit_high) begin
                     high_half_in = unit[9:0];
                     mode_in      = jsu_pkg::MODE_NEED_BS;
                  end else if (unit_low) begin
                     has_result     = 1'b1;
                     job.kind       = jsu_pkg::KIND_ERROR;
                     job.error_code = jsu_pkg::ERR_LONE_LOW;
                     mode_in        = jsu_pkg::MODE_WAIT;
                  end else begin
                     has_result = 1'b1;
                     job.is_cp  = 1'b1;
                     job.value  = {5'd0, unit};
                     mode_in    = jsu_pkg::MODE_BODY;
                  end
               end else begin
                  has_result = 1'b1;
                  if (unit_low) begin
                     job.is_cp = 1'b1;
                     job.value = {1'b0, high_half_ff, unit[9:0]} + 21'h10000;
                     mode_in   = jsu_pkg::MODE_BODY;
                  end else begin
                     job.kind       = jsu_pkg::KIND_ERROR;
                     job.error_code = jsu_pkg::ERR_BAD_LOW;
                     mode_in        = jsu_pkg::MODE_WAIT;
                  end
               end
            end
         end
         jsu_pkg::MODE_NEED_BS, jsu_pkg::MODE_NEED_U: begin
            if (end_of_text || (mode_ff == jsu_pkg::MODE_NEED_BS && text_byte != 8'h5C)
                || (mode_ff == jsu_pkg::MODE_NEED_U && text_byte != 8'h75)) begin
               has_result     = 1'b1;
               job.kind       = jsu_pkg::KIND_ERROR;
               job.error_code = jsu_pkg::ERR_LONE_HIGH;
               mode_in        = jsu_pkg::MODE_WAIT;
            end else if (mode_ff == jsu_pkg::MODE_NEED_BS) begin
               mode_in = jsu_pkg::MODE_NEED_U;
            end else begin
               mode_in      = jsu_pkg::MODE_HEX2;
               hex_accum_in = 16'd0;
               hex_count_in = 2'd0;
            end
         end
         default: begin
            mode_in = jsu_pkg::MODE_WAIT;
            if (end_of_text || text_byte == 8'h20 || text_byte inside {[8'h09:8'h0D]}) begin
               mode_in = jsu_pkg::MODE_WAIT;
            end else if (text_byte == 8'h22) begin
               mode_in = jsu_pkg::MODE_BODY;
            end else begin
               has_result     = 1'b1;
               job.kind       = jsu_pkg::KIND_ERROR;
               job.error_code = jsu_pkg::ERR_NO_QUOTE;
            end
         end
      endcase

      if (job.kind != jsu_pkg::KIND_BYTE) begin
         job.value = 21'd0;
      end
   end

   assign job_valid = accept && has_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= jsu_pkg::MODE_WAIT;
         hex_accum_ff <= 16'd0;
         hex_count_ff <= 2'd0;
         high_half_ff <= 10'd0;
      end else if (accept) begin
         mode_ff      <= mode_in;
         hex_accum_ff <= hex_accum_in;
         hex_count_ff <= hex_count_in;
         high_half_ff <= high_half_in;
      end
   end

endmodule

[hw/rtl/jsu_queue.sv]
// Job queue between front and back end: per cycle, one job in unless full and one out unless empty.
// Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_queue #(
   parameter int DEPTH = jsu_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  jsu_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output jsu_pkg::job_type pop_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   jsu_pkg::job_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign valid   = (count_ff != '0);
   assign pop_job = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[hw/rtl/jsu_back.sv]
// Back end: holds one job and expands it into result beats, code points into
// one to four UTF-8 bytes. Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  jsu_pkg::job_type q_job,
   output logic             q_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_out_byte,
   output logic [3:0]       rsp_error_code,
   output logic             rsp_last
);

   logic             valid_ff, valid_in;
   jsu_pkg::job_type job_ff, job_in;
   logic [1:0]       idx_ff, idx_in;
   logic [1:0]       final_idx;
   logic [20:0]      cp;
   logic             load;

   assign cp = job_ff.value;

   always_comb begin
      if (cp <= 21'h7F) begin
         final_idx = 2'd0;
      end else if (cp <= 21'h7FF) begin
         final_idx = 2'd1;
      end else if (cp <= 21'hFFFF) begin
         final_idx = 2'd2;
      end else begin
         final_idx = 2'd3;
      end
   end

   always_comb begin
      rsp_out_byte = cp[7:0];
      if (job_ff.is_cp) begin
         case (final_idx)
            2'd0: rsp_out_byte = {1'b0, cp[6:0]};
            2'd1: begin
               case (idx_ff)
                  2'd0:    rsp_out_byte = {3'b110, cp[10:6]};
                  default: rsp_out_byte = {2'b10, cp[5:0]};
               endcase
            end
            2'd2: begin
               case (idx_ff)
                  2'd0:    rsp_out_byte = {4'b1110, cp[15:12]};
                  2'd1:    rsp_out_byte = {2'b10, cp[11:6]};
                  default: rsp_out_byte = {2'b10, cp[5:0]};
               endcase
            end
            default: begin
               case (idx_ff)
                  2'd0:    rsp_out_byte = {5'b11110, cp[20:18]};
                  2'd1:    rsp_out_byte = {2'b10, cp[17:12]};
                  2'd2:    rsp_out_byte = {2'b10, cp[11:6]};
                  default: rsp_out_byte = {2'b10, cp[5:0]};
               endcase
            end
         endcase
      end
   end

   assign rsp_empty      = !valid_ff;
   assign rsp_kind       = job_ff.kind;
   assign rsp_error_code = job_ff.error_code;
   assign rsp_last       = !job_ff.is_cp || (idx_ff == final_idx);

   assign load  = !valid_ff || (rsp_pop && rsp_last);
   assign q_pop = load && q_valid;

   always_comb begin
      valid_in = valid_ff;
      job_in   = job_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = q_valid;
         job_in   = q_job;
         idx_in   = 2'd0;
      end else if (rsp_pop) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

[hw/rtl/json_string_unescape_utf8.sv]
// Top level of the JSON string unescaper: front end, job queue and back end.
// Depends on jsu_pkg, jsu_front, jsu_queue and jsu_back.
`timescale 1ns / 1ps

// One text byte is accepted per cycle whenever req_full is low, and one result
// beat leaves per cycle when rsp_pop is high and rsp_empty is low. The front
// end decodes each byte in the cycle it is accepted and places all of that
// byte's results in a job queue of QUEUE_DEPTH entries; req_full is high only
// while that queue is full. The back end turns a job into one beat, or one to
// four beats for an escaped code point; a job goes from the queue into the
// back end's job register. Multi-byte UTF-8 bursts are absorbed by the queue,
// since escapes spend at least five bytes without results before each burst.

module json_string_unescape_utf8 #(
   parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_text_byte,
   input  logic       req_end_of_text,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic [3:0] rsp_error_code,
   output logic       rsp_last
);

   logic             accept;
   logic             job_valid;
   jsu_pkg::job_type job;
   logic             q_valid;
   logic             q_pop;
   jsu_pkg::job_type q_job;

   assign accept = req_push && !req_full;

   jsu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .text_byte   (req_text_byte),
      .end_of_text (req_end_of_text),
      .job_valid   (job_valid),
      .job         (job)
   );

   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_valid),
      .push_job (job),
      .full     (req_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .pop_job  (q_job)
   );

   jsu_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_job          (q_job),
      .q_pop          (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_kind       (rsp_kind),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_error_code (rsp_error_code),
      .rsp_last       (rsp_last)
   );

endmodule

[tb/tb_json_string_unescape_utf8.sv]
// Self-checking testbench for json_string_unescape_utf8: directed and random JSON text,
// with an in-bench predictor of the unescaper and a per-beat result checker.
// Depends on jsu_pkg and the json_string_unescape_utf8 RTL.
`timescale 1ns / 1ps

module tb_json_string_unescape_utf8;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 20;
   localparam int RANDOM_ITEMS = 48;

   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   // the eight single-byte escape letters: " \ / b f n r t
   localparam logic [63:0] ESCAPE_CHARS = {8'h22, 8'h5C, 8'h2F, 8'h62,
                                           8'h66, 8'h6E, 8'h72, 8'h74};

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_byte;
      logic [3:0] error_code;
      logic       last;
   } text_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [7:0] req_text_byte = 8'h00;
   logic       req_end_of_text = 1'b0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_out_byte;
   logic [3:0] rsp_error_code;
   logic       rsp_last;

   // predictor state
   jsu_pkg::mode_type exp_mode = jsu_pkg::MODE_WAIT;
   logic [15:0] exp_hex = 16'h0000;
   logic [1:0]  exp_hex_count = 2'd0;
   logic [9:0]  exp_high = 10'h000;

   text_beat_type byte_results [0:3];
   int            byte_result_count;
   text_beat_type decoded_queue [$];

   int failures = 0;
   int cycle_count = 0;
   int useful_count = 0;
   int burst_left = 0;
   bit sender_steady = 1'b0;
   int pop_style = 0;
   int pop_left = 0;
   int pop_tick = 0;

   json_string_unescape_utf8 u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_text_byte   (req_text_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_kind        (rsp_kind),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_error_code  (rsp_error_code),
      .rsp_last        (rsp_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   function void add_result(input logic [1:0] kind, input logic [7:0] value,
                            input logic [3:0] code);
      byte_results[byte_result_count] = '{kind, value, code, 1'b0};
      byte_result_count++;
   endfunction

   function void add_error(input logic [3:0] code);
      exp_mode = jsu_pkg::MODE_WAIT;
      add_result(jsu_pkg::KIND_ERROR, 8'h00, code);
   endfunction

   function void add_utf8(input logic [20:0] cp);
      if (cp <= 21'h7F) begin
         add_result(jsu_pkg::KIND_BYTE, cp[7:0], jsu_pkg::ERR_NONE);
      end else if (cp <= 21'h7FF) begin
         add_result(jsu_pkg::KIND_BYTE, {3'b110, cp[10:6]}, jsu_pkg::ERR_NONE);
         add_result(jsu_pkg::KIND_BYTE, {2'b10, cp[5:0]}, jsu_pkg::ERR_NONE);
      end else if (cp <= 21'hFFFF) begin
         add_result(jsu_pkg::KIND_BYTE, {4'b1110, cp[15:12]}, jsu_pkg::ERR_NONE);
         add_result(jsu_pkg::KIND_BYTE, {2'b10, cp[11:6]}, jsu_pkg::ERR_NONE);
         add_result(jsu_pkg::KIND_BYTE, {2'b10, cp[5:0]}, jsu_pkg::ERR_NONE);
      end else begin
         add_result(jsu_pkg::KIND_BYTE, {5'b11110, cp[20:18]}, jsu_pkg::ERR_NONE);
         add_result(jsu_pkg::KIND_BYTE, {2'b10, cp[17:12]}, jsu_pkg::ERR_NONE);
         add_result(jsu_pkg::KIND_BYTE, {2'b10, cp[11:6]}, jsu_pkg::ERR_NONE);
         add_result(jsu_pkg::KIND_BYTE, {2'b10, cp[5:0]}, jsu_pkg::ERR_NONE);
      end
   endfunction

   task automatic unescape_byte(input logic [7:0] b, input logic eot);
      logic [7:0]  nib;
      logic        is_hex;
      logic [15:0] u;
      int          i;
      byte_result_count = 0;
      is_hex = 1'b1;
      nib = 8'h00;
      if (b >= "0" && b <= "9") nib = b - 8'h30;
      else if (b >= "a" && b <= "f") nib = b - 8'h57;
      else if (b >= "A" && b <= "F") nib = b - 8'h37;
      else is_hex = 1'b0;

      case (exp_mode)
         jsu_pkg::MODE_BODY: begin
            if (eot) add_error(jsu_pkg::ERR_UNTERMINATED);
            else if (b == CH_QUOTE) begin
               exp_mode = jsu_pkg::MODE_WAIT;
               add_result(jsu_pkg::KIND_DONE, 8'h00, jsu_pkg::ERR_NONE);
            end else if (b == CH_BACKSLASH) exp_mode = jsu_pkg::MODE_ESC;
            else add_result(jsu_pkg::KIND_BYTE, b, jsu_pkg::ERR_NONE);
         end
         jsu_pkg::MODE_ESC: begin
            if (eot) add_error(jsu_pkg::ERR_CUT_ESCAPE);
            else begin
               exp_mode = jsu_pkg::MODE_BODY;
               case (b)
                  CH_QUOTE, CH_BACKSLASH, "/":
                     add_result(jsu_pkg::KIND_BYTE, b, jsu_pkg::ERR_NONE);
                  "b": add_result(jsu_pkg::KIND_BYTE, 8'h08, jsu_pkg::ERR_NONE);
                  "f": add_result(jsu_pkg::KIND_BYTE, 8'h0C, jsu_pkg::ERR_NONE);
                  "n": add_result(jsu_pkg::KIND_BYTE, 8'h0A, jsu_pkg::ERR_NONE);
                  "r": add_result(jsu_pkg::KIND_BYTE, 8'h0D, jsu_pkg::ERR_NONE);
                  "t": add_result(jsu_pkg::KIND_BYTE, 8'h09, jsu_pkg::ERR_NONE);
                  "u": begin
                     exp_mode = jsu_pkg::MODE_HEX1;
                     exp_hex = 16'h0000;
                     exp_hex_count = 2'd0;
                  end
                  default: add_error(jsu_pkg::ERR_BAD_ESCAPE);
               endcase
            end
         end
         jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
            if (eot) add_error(jsu_pkg::ERR_CUT_HEX);
            else if (!is_hex) add_error(jsu_pkg::ERR_BAD_HEX);
            else begin
               exp_hex = {exp_hex[11:0], nib[3:0]};
               if (exp_hex_count != 2'd3) exp_hex_count++;
               else begin
                  u = exp_hex;
                  exp_hex = 16'h0000;
                  exp_hex_count = 2'd0;
                  if (exp_mode == jsu_pkg::MODE_HEX1) begin
                     if (u >= 16'hD800 && u <= 16'hDBFF) begin
                        exp_high = u[9:0];
                        exp_mode = jsu_pkg::MODE_NEED_BS;
                     end else if (u >= 16'hDC00 && u <= 16'hDFFF) begin
                        add_error(jsu_pkg::ERR_LONE_LOW);
                     end else begin
                        exp_mode = jsu_pkg::MODE_BODY;
                        add_utf8({5'd0, u});
                     end
                  end else if (!(u >= 16'hDC00 && u <= 16'hDFFF)) begin
                     add_error(jsu_pkg::ERR_BAD_LOW);
                  end else begin
                     exp_mode = jsu_pkg::MODE_BODY;
                     add_utf8(21'h10000 + {1'b0, exp_high, u[9:0]});
                  end
               end
            end
         end
         jsu_pkg::MODE_NEED_BS: begin
            if (eot || b != CH_BACKSLASH) add_error(jsu_pkg::ERR_LONE_HIGH);
            else exp_mode = jsu_pkg::MODE_NEED_U;
         end
         jsu_pkg::MODE_NEED_U: begin
            if (eot || b != "u") add_error(jsu_pkg::ERR_LONE_HIGH);
            else begin
               exp_mode = jsu_pkg::MODE_HEX2;
               exp_hex = 16'h0000;
               exp_hex_count = 2'd0;
            end
         end
         default: begin
            exp_mode = jsu_pkg::MODE_WAIT;
            if (!eot) begin
               if (b == 8'h20 || (b >= 8'h09 && b <= 8'h0D)) exp_mode = jsu_pkg::MODE_WAIT;
               else if (b == CH_QUOTE) exp_mode = jsu_pkg::MODE_BODY;
               else add_error(jsu_pkg::ERR_NO_QUOTE);
            end
         end
      endcase

      for (i = 0; i < byte_result_count; i++) begin
         if (i == byte_result_count - 1) byte_results[i].last = 1'b1;
         decoded_queue.insert(decoded_queue.size(), byte_results[i]);
      end
   endtask

   // ---------------------------------------------------------------- checker

   always @(posedge clock) begin : check_beat
      text_beat_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (decoded_queue.size() == 0) begin
            $error("unexpected beat: kind %0d out_byte %h error_code %0d last %0d",
                   rsp_kind, rsp_out_byte, rsp_error_code, rsp_last);
            failures++;
         end else begin
            want = decoded_queue.pop_front();
            if (rsp_kind !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_kind);
               failures++;
            end
            if (rsp_out_byte !== want.out_byte) begin
               $error("out_byte: expected %h, got %h", want.out_byte, rsp_out_byte);
               failures++;
            end
            if (rsp_error_code !== want.error_code) begin
               $error("error_code: expected %0d, got %0d", want.error_code, rsp_error_code);
               failures++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_last);
               failures++;
            end
         end
      end
   end

   // receiver: switch between four stall styles at random
   always @(posedge clock) begin
      if (pop_left == 0) begin
         pop_style = $urandom_range(0, 3);
         pop_left = $urandom_range(16, 96);
      end
      pop_left--;
      pop_tick++;
      case (pop_style)
         0: rsp_pop <= 1'b1;
         1: rsp_pop <= (pop_tick % 4 != 3);
         2: rsp_pop <= 1'($urandom_range(0, 1));
         default: rsp_pop <= (pop_tick % 16 == 0);
      endcase
   end

   // ---------------------------------------------------------------- sender

   task automatic push_text(input logic [7:0] b, input logic eot = 1'b0);
      int gap;
      if (burst_left == 0) begin
         gap = (sender_steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 10);
      end
      burst_left--;
      if (!(exp_mode == jsu_pkg::MODE_WAIT
            && (eot || b == 8'h20 || (b >= 8'h09 && b <= 8'h0D))))
         useful_count++;
      req_push <= 1'b1;
      req_text_byte <= b;
      req_end_of_text <= eot;
      @(posedge clock);
      while (req_full) @(posedge clock);
      unescape_byte(b, eot);
   endtask

   task automatic push_end();
      push_text(8'($urandom_range(0, 255)), 1'b1);
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return 8'h30 + n;
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + (n - 4'd10);
   endfunction

   task automatic push_hex_digits(input int count);
      repeat (count) push_text(hex_char(4'($urandom_range(0, 15))));
   endtask

   task automatic push_u_escape(input logic [15:0] v);
      int i;
      push_text(CH_BACKSLASH);
      push_text("u");
      for (i = 3; i >= 0; i--) push_text(hex_char(v[i*4 +: 4]));
   endtask

   task automatic wait_for_results();
      req_push <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (decoded_queue.size() != 0) @(posedge clock);
   endtask

   function automatic logic [15:0] random_bmp();
      case ($urandom_range(0, 3))
         0: return 16'($urandom_range(16'h0000, 16'h007F));
         1: return 16'($urandom_range(16'h0080, 16'h07FF));
         2: return 16'($urandom_range(16'h0800, 16'hD7FF));
         default: return 16'($urandom_range(16'hE000, 16'hFFFF));
      endcase
   endfunction

   task automatic push_element();
      logic [7:0] b;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE || b == CH_BACKSLASH);
            push_text(b);
         end
         4, 5: begin
            push_text(CH_BACKSLASH);
            push_text(ESCAPE_CHARS[$urandom_range(0, 7)*8 +: 8]);
         end
         6, 7: push_u_escape(random_bmp());
         default: begin
            push_u_escape(16'hD800 + 16'($urandom_range(0, 1023)));
            push_u_escape(16'hDC00 + 16'($urandom_range(0, 1023)));
         end
      endcase
   endtask

   task automatic push_fault();
      logic [7:0]  b;
      logic [15:0] v;
      int          i;
      logic        known;
      case ($urandom_range(0, 8))
         0: push_end();
         1: begin
            push_text(CH_BACKSLASH);
            push_end();
         end
         2: begin
            push_text(CH_BACKSLASH);
            push_text("u");
            push_hex_digits($urandom_range(0, 3));
            push_end();
         end
         3: begin
            push_text(CH_BACKSLASH);
            push_text("u");
            push_hex_digits($urandom_range(0, 3));
            do b = 8'($urandom_range(0, 255));
            while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F"));
            push_text(b);
         end
         4: begin
            push_u_escape(16'hD800 + 16'($urandom_range(0, 1023)));
            if ($urandom_range(0, 1)) push_end();
            else begin
               do b = 8'($urandom_range(0, 255)); while (b == CH_BACKSLASH);
               push_text(b);
            end
         end
         5: begin
            push_u_escape(16'hD800 + 16'($urandom_range(0, 1023)));
            push_text(CH_BACKSLASH);
            if ($urandom_range(0, 1)) push_end();
            else begin
               do b = 8'($urandom_range(0, 255)); while (b == "u");
               push_text(b);
            end
         end
         6: begin
            push_u_escape(16'hD800 + 16'($urandom_range(0, 1023)));
            do v = 16'($urandom_range(0, 16'hFFFF)); while (v >= 16'hDC00 && v <= 16'hDFFF);
            push_u_escape(v);
         end
         7: push_u_escape(16'hDC00 + 16'($urandom_range(0, 1023)));
         default: begin
            push_text(CH_BACKSLASH);
            do begin
               b = 8'($urandom_range(0, 255));
               known = (b == "u");
               for (i = 0; i < 8; i++) if (b == ESCAPE_CHARS[i*8 +: 8]) known = 1'b1;
            end while (known);
            push_text(b);
         end
      endcase
   endtask

   task automatic push_string(input bit broken);
      int len;
      int pick;
      repeat ($urandom_range(0, 2)) begin
         pick = $urandom_range(8, 13);
         push_text(pick == 8 ? 8'h20 : 8'(pick));
      end
      push_text(CH_QUOTE);
      len = $urandom_range(0, 6);
      repeat (len) push_element();
      if (broken) push_fault();
      else push_text(CH_QUOTE);
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_whitespace_and_quote();
      push_text(8'h20);
      push_text(8'h09);
      push_text(8'h0A);
      push_text(8'h0B);
      push_text(8'h0C);
      push_text(8'h0D);
      push_end();
      push_text("x");
      push_text(CH_QUOTE);
      push_text(8'h00);
      push_text(8'hFF);
      push_text(8'h80);
      push_text(8'h7F);
      push_text(CH_QUOTE);
   endtask

   task automatic test_simple_escapes();
      int i;
      push_text(CH_QUOTE);
      for (i = 0; i < 8; i++) begin
         push_text(CH_BACKSLASH);
         push_text(ESCAPE_CHARS[i*8 +: 8]);
      end
      push_text(CH_QUOTE);
   endtask

   task automatic test_unicode_escapes();
      push_text(CH_QUOTE);
      push_u_escape(16'h0000);
      push_u_escape(16'h007F);
      push_u_escape(16'h0080);
      push_u_escape(16'h07FF);
      push_u_escape(16'h0800);
      push_u_escape(16'hFFFF);
      push_u_escape(16'hD800);
      push_u_escape(16'hDC00);
      push_u_escape(16'hDBFF);
      push_u_escape(16'hDFFF);
      push_text(CH_QUOTE);
   endtask

   task automatic test_faults();
      // end of text in the body
      push_text(CH_QUOTE);
      push_end();
      // end of text after a backslash
      push_text(CH_QUOTE);
      push_text(CH_BACKSLASH);
      push_end();
      // end of text inside the hex digits
      push_text(CH_QUOTE);
      push_text(CH_BACKSLASH);
      push_text("u");
      push_text("1");
      push_text("2");
      push_end();
      // non-hex digit
      push_text(CH_QUOTE);
      push_text(CH_BACKSLASH);
      push_text("u");
      push_text("g");
      // high surrogate cut by end of text, by a stray byte, by a missing u
      push_text(CH_QUOTE);
      push_u_escape(16'hD800);
      push_end();
      push_text(CH_QUOTE);
      push_u_escape(16'hD834);
      push_text("x");
      push_text(CH_QUOTE);
      push_u_escape(16'hD834);
      push_text(CH_BACKSLASH);
      push_text("x");
      // high surrogate followed by a non-low escape
      push_text(CH_QUOTE);
      push_u_escape(16'hD834);
      push_u_escape(16'h0041);
      // low surrogate on its own
      push_text(CH_QUOTE);
      push_u_escape(16'hDC00);
      // unknown escape letter
      push_text(CH_QUOTE);
      push_text(CH_BACKSLASH);
      push_text("q");
   endtask

   task automatic test_random_text();
      int start;
      bit paused;
      int pick;
      start = useful_count;
      paused = 1'b0;
      while (useful_count - start < RANDOM_ITEMS) begin
         if (!paused && useful_count - start >= RANDOM_ITEMS / 2) begin
            wait_for_results();
            paused = 1'b1;
         end
         sender_steady = ($urandom_range(0, 4) == 0);
         pick = $urandom_range(0, 9);
         if (pick < 6) push_string(1'b0);
         else if (pick < 8) push_string(1'b1);
         else begin
            repeat ($urandom_range(1, 3)) push_text(8'($urandom_range(0, 255)));
            push_end();
         end
      end
      sender_steady = 1'b0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_whitespace_and_quote();
      test_simple_escapes();
      test_unicode_escapes();
      test_faults();
      test_random_text();
      req_push <= 1'b0;
      @(posedge clock);
      while (decoded_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && decoded_queue.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[sim.f]
hw/rtl/jsu_pkg.sv
hw/rtl/jsu_front.sv
hw/rtl/jsu_queue.sv
hw/rtl/jsu_back.sv
hw/rtl/json_string_unescape_utf8.sv
tb/tb_json_string_unescape_utf8.sv
